/* design/fcct_pkg.sv */
`timescale 1ns / 1ps
package fcct_pkg;

	// Number of timers and widths fixed by the register map.
	localparam int TIMERS_DEF = 4;
	localparam int TIMER_W    = 2;
	localparam int DIV_STEPS  = 17;

	localparam logic [15:0] EXT_DIV_RESET = 16'd18773;

	// Action codes.
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_READ   = 3'd1;
	localparam logic [2:0] ACT_WRITE  = 3'd2;
	localparam logic [2:0] ACT_VSTART = 3'd3;
	localparam logic [2:0] ACT_VEND   = 3'd4;

	// Register offsets.
	localparam logic [10:0] OFF_COUNT   = 11'h000;
	localparam logic [10:0] OFF_MODE    = 11'h010;
	localparam logic [10:0] OFF_COMPARE = 11'h020;
	localparam logic [10:0] OFF_HOLD    = 11'h030;

	// Mode bit positions.
	localparam int MB_GATE_EN   = 2;
	localparam int MB_GATE_SEL  = 3;
	localparam int MB_GATE_RISE = 4;
	localparam int MB_GATE_FALL = 5;
	localparam int MB_ZERO_RET  = 6;
	localparam int MB_COUNT_EN  = 7;
	localparam int MB_EQ_IE     = 8;
	localparam int MB_OV_IE     = 9;
	localparam int MB_EQ_FLAG   = 10;
	localparam int MB_OV_FLAG   = 11;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] tick_count;
		logic [12:0] address;
		logic [15:0] write_data;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [3:0]  irq_lines;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               accept;
		logic               load;
		logic               step;
		logic               apply;
		logic               finish;
		logic [TIMER_W-1:0] timer;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
		logic enabled;
	} status_t;

endpackage

/* design/four_channel_compare_timer.sv */
`timescale 1ns / 1ps
// Four-channel compare timer.
// Items arrive on item/item_valid/item_stall; one result per item leaves on
// result/result_valid/result_stall. A transaction completes when valid is high
// and stall is low. The external divider is written through cfg_valid/cfg_data;
// cfg_ready is always high and writes are expected only while the block is idle.
// Register reads, writes and vblank edges take effect at acceptance and their
// result is presented the next cycle; a new item may then be accepted.
// A tick runs the timers one after another through a shared 17-step restoring
// divider: a disabled timer is skipped; an enabled timer is loaded, divided and
// updated; then a finishing state presents the result, after which the next
// item may be taken.
// Reset clears all timer registers and sets the external divider to 18773.
// While the result is stalled it holds, and no new item is accepted.
module four_channel_compare_timer #(
	parameter int TIMERS = fcct_pkg::TIMERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fcct_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fcct_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	fcct_pkg::cmd_t    cmd;
	fcct_pkg::status_t status;

	assign cfg_ready = 1'b1;

	// Sequencer.
	fcct_ctrl #(.TIMERS(TIMERS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.is_tick    (item.action == fcct_pkg::ACT_TICK),
		.status     (status),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// Registers, divider and output stage.
	fcct_dp #(.TIMERS(TIMERS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.status       (status)
	);

endmodule

/* design/fcct_ctrl.sv */
`timescale 1ns / 1ps
module fcct_ctrl #(
	parameter int TIMERS = fcct_pkg::TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               is_tick,
	input  fcct_pkg::status_t  status,
	output logic               item_stall,
	output fcct_pkg::cmd_t     cmd
);

	localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	fcct_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] timer_q, timer_d;
	logic [4:0]       bit_q, bit_d;
	logic             last;

	assign last = (timer_q == IDX_W'(TIMERS - 1));

	// State, timer index and divider step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcct_pkg::ST_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		timer_d    = timer_q;
		bit_d      = bit_q;
		cmd        = '0;
		cmd.timer  = fcct_pkg::TIMER_W'(timer_q);
		item_stall = 1'b1;
		unique case (state_q)
			fcct_pkg::ST_IDLE: begin
				item_stall = status.out_busy;
				if (item_valid && !status.out_busy) begin
					cmd.accept = 1'b1;
					timer_d    = '0;
					if (is_tick) state_d = fcct_pkg::ST_SEL;
				end
			end
			fcct_pkg::ST_SEL: begin
				if (status.enabled) begin
					cmd.load = 1'b1;
					bit_d    = '0;
					state_d  = fcct_pkg::ST_DIV;
				end else if (last) begin
					state_d = fcct_pkg::ST_DONE;
				end else begin
					timer_d = timer_q + 1'b1;
				end
			end
			fcct_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				bit_d    = bit_q + 1'b1;
				if (bit_q == 5'(fcct_pkg::DIV_STEPS - 1)) state_d = fcct_pkg::ST_APPLY;
			end
			fcct_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				if (last) begin
					state_d = fcct_pkg::ST_DONE;
				end else begin
					timer_d = timer_q + 1'b1;
					state_d = fcct_pkg::ST_SEL;
				end
			end
			fcct_pkg::ST_DONE: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = fcct_pkg::ST_IDLE;
				end
			end
			default: state_d = fcct_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/fcct_dp.sv */
`timescale 1ns / 1ps
module fcct_dp #(
	parameter int TIMERS = fcct_pkg::TIMERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fcct_pkg::item_t     item,
	input  fcct_pkg::cmd_t      cmd,
	input  logic                cfg_valid,
	input  logic [15:0]         cfg_data,
	input  logic                result_stall,
	output logic                result_valid,
	output fcct_pkg::result_t   result,
	output fcct_pkg::status_t   status
);

	localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	logic [15:0] count_q [TIMERS];
	logic [11:0] mode_q  [TIMERS];
	logic [15:0] cmp_q   [TIMERS];
	logic [15:0] hold_q  [TIMERS];
	logic [15:0] rem_q   [TIMERS];
	logic [15:0] ext_div_q;
	logic [15:0] ticks_q;
	logic [16:0] quo_q;
	logic [15:0] part_q;
	logic [15:0] dvs_q;
	logic [3:0]  irq_q;
	logic        out_valid_q;
	fcct_pkg::result_t out_q;

	logic [IDX_W-1:0] t;
	logic [IDX_W-1:0] at;
	logic             at_ok;
	logic [10:0]      off;
	logic [15:0]      divisor;
	logic [16:0]      trial;
	logic             ge;
	logic [16:0]      diff;
	logic [17:0]      next_cnt, cmp_val, cnt;
	logic             eq, ov;
	logic [15:0]      rd;

	assign t     = cmd.timer[IDX_W-1:0];
	assign at    = item.address[11 +: IDX_W];
	assign at_ok = ({1'b0, item.address[12:11]} < 3'(TIMERS));
	assign off   = item.address[10:0];

	assign status.enabled  = mode_q[t][fcct_pkg::MB_COUNT_EN];
	assign status.out_busy = out_valid_q && result_stall;
	assign result_valid    = out_valid_q;
	assign result          = out_q;

	// Prescaler selection for the timer being served.
	always_comb begin
		unique case (mode_q[t][1:0])
			2'd0:    divisor = 16'd2;
			2'd1:    divisor = 16'd32;
			2'd2:    divisor = 16'd512;
			default: divisor = (ext_div_q == 16'd0) ? 16'd1 : ext_div_q;
		endcase
	end

	// One restoring division step.
	assign trial = {part_q, quo_q[16]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	// Count update from the finished quotient.
	always_comb begin
		next_cnt = {2'b00, count_q[t]} + {1'b0, quo_q};
		cmp_val  = (cmp_q[t] == 16'd0) ? 18'h10000 : {2'b00, cmp_q[t]};
		eq       = ({2'b00, count_q[t]} < cmp_val) && (next_cnt >= cmp_val);
		cnt      = (eq && mode_q[t][fcct_pkg::MB_ZERO_RET]) ? next_cnt - cmp_val : next_cnt;
		ov       = (cnt[17:16] != 2'b00);
	end

	// Register read data.
	always_comb begin
		rd = '0;
		if (item.action == fcct_pkg::ACT_READ && at_ok) begin
			unique case (off)
				fcct_pkg::OFF_COUNT:   rd = count_q[at];
				fcct_pkg::OFF_MODE:    rd = {4'b0, mode_q[at]};
				fcct_pkg::OFF_COMPARE: rd = cmp_q[at];
				fcct_pkg::OFF_HOLD:    rd = hold_q[at];
				default:               rd = '0;
			endcase
		end
	end

	// Timer registers and external divider configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++) begin
				count_q[i] <= '0;
				mode_q[i]  <= '0;
				cmp_q[i]   <= '0;
				hold_q[i]  <= '0;
				rem_q[i]   <= '0;
			end
			ext_div_q <= fcct_pkg::EXT_DIV_RESET;
		end else begin
			if (cfg_valid) ext_div_q <= cfg_data;
			if (cmd.accept) begin
				if (item.action == fcct_pkg::ACT_WRITE && at_ok) begin
					unique case (off)
						fcct_pkg::OFF_COUNT:   count_q[at] <= item.write_data;
						fcct_pkg::OFF_MODE:    mode_q[at]  <= {mode_q[at][11:10]
							& ~item.write_data[11:10], item.write_data[9:0]};
						fcct_pkg::OFF_COMPARE: cmp_q[at]   <= item.write_data;
						fcct_pkg::OFF_HOLD:    hold_q[at]  <= item.write_data;
						default: ;
					endcase
				end
				// Vblank edges clear gated timers.
				for (int i = 0; i < TIMERS; i++) begin
					if (mode_q[i][fcct_pkg::MB_COUNT_EN] && mode_q[i][fcct_pkg::MB_GATE_EN]
						&& mode_q[i][fcct_pkg::MB_GATE_SEL]
						&& ((item.action == fcct_pkg::ACT_VSTART
							&& mode_q[i][fcct_pkg::MB_GATE_RISE])
						|| (item.action == fcct_pkg::ACT_VEND
							&& mode_q[i][fcct_pkg::MB_GATE_FALL]))) begin
						count_q[i] <= '0;
						rem_q[i]   <= '0;
					end
				end
			end
			if (cmd.apply) begin
				count_q[t] <= cnt[15:0];
				rem_q[t]   <= part_q;
				mode_q[t]  <= mode_q[t] | {ov, eq, 10'b0};
			end
		end
	end

	// Divider working registers and tick latch.
	always_ff @(posedge clk) begin
		if (cmd.accept) ticks_q <= item.tick_count;
		if (cmd.load) begin
			quo_q  <= {1'b0, rem_q[t]} + {1'b0, ticks_q};
			part_q <= '0;
			dvs_q  <= divisor;
		end else if (cmd.step) begin
			part_q <= ge ? diff[15:0] : trial[15:0];
			quo_q  <= {quo_q[15:0], ge};
		end
	end

	// Interrupt collection and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) irq_q <= '0;
			else if (cmd.apply && ((eq && mode_q[t][fcct_pkg::MB_EQ_IE])
				|| (ov && mode_q[t][fcct_pkg::MB_OV_IE])))
				irq_q[cmd.timer] <= 1'b1;
			if ((cmd.accept && item.action != fcct_pkg::ACT_TICK) || cmd.finish)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.action != fcct_pkg::ACT_TICK) begin
			out_q.read_data <= rd;
			out_q.irq_lines <= '0;
		end else if (cmd.finish) begin
			out_q.read_data <= '0;
			out_q.irq_lines <= irq_q;
		end
	end

endmodule

/* design/fcct_checker.sv */
`timescale 1ns / 1ps
module fcct_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input fcct_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input fcct_pkg::result_t result
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// No item is taken while the result is blocked.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("item accepted while result blocked");

	// Non-tick items answer on the next cycle.
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.action != fcct_pkg::ACT_TICK |=> result_valid)
		else $error("missing result after register transaction");

	// A tick keeps the input stalled while the timers are served.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.action == fcct_pkg::ACT_TICK |=> item_stall)
		else $error("input not stalled during tick");

endmodule

bind four_channel_compare_timer fcct_checker u_fcct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
